>>> src/bcta_pkg.sv
// Package: types, constants and codes of the bundle consensus task allocator.
package bcta_pkg;
	localparam int MaxTasks = 64;
	localparam int MaxBundle = 8;
	localparam int CostWidth = 32;
	localparam int TaskW = $clog2(MaxTasks);
	localparam int SlotW = $clog2(MaxBundle);
	localparam int CountW = $clog2(MaxBundle + 1);
	localparam int IdW = 8;
	localparam logic [CostWidth-1:0] CostInf = '1;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_LOAD = 3'd1,
		OP_PEER = 3'd2,
		OP_REBUILD = 3'd3,
		OP_READ = 3'd4
	} op_t;

	typedef enum logic [0:0] {
		CFG_AGENT_ID = 1'd0,
		CFG_BUNDLE_LIMIT = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_CUT_RD,
		ST_CUT_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_CLAIM,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT,
		ST_SINGLE
	} state_t;
endpackage

>>> src/bundle_consensus_task_allocator.sv
// Top level: task table, bundle and the sequencer that runs each operation.
//
// One operation is taken at a time; s_axis_tready is low until its last result is
// transferred. Clear and unused operations go straight to their single result. Load, peer
// entry and read first read the task table RAM, then update it (load and peer entry only).
// Rebuild goes through the bundle once, slot by slot, to find the cut. While the bundle is
// below its limit it then scans all 64 tasks through the single table read port and one
// shared compare, then claims the best one found. It scans once for each slot claimed, and
// once more when nothing is left to claim. Last it reads out each bundle entry. There is
// no clearing pass after reset.
module bundle_consensus_task_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: [2:0] operation, [8:3] task_index, [40:9] amount, [48:41] winner_id,
	// [56:49] sender_id, [57] first_of_message, [63:58] zero
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: [5:0] task_out, [37:6] bid_out, [45:38] winner_out, [49:46] bundle_count,
	// [50] changed_flag, [51] entry_valid, [55:52] zero
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int TW = bcta_pkg::TaskW;
	localparam int CW = bcta_pkg::CostWidth;
	localparam int SW = bcta_pkg::SlotW;
	localparam int NW = bcta_pkg::CountW;
	localparam int EW = CW + CW + bcta_pkg::IdW;

	bcta_pkg::state_t state_q, state_d;

	logic [7:0] own_id_q;
	logic [3:0] limit_q;
	logic [bcta_pkg::MaxTasks-1:0] loaded_q, inb_q;
	logic [NW-1:0] blen_q;
	logic changed_q;
	logic [TW-1:0] bl_q [bcta_pkg::MaxBundle];

	logic [2:0] op_q;
	logic [TW-1:0] idx_q;
	logic [CW-1:0] amt_q;
	logic [7:0] win_q, snd_q;
	logic first_q;

	logic [TW-1:0] scan_q, pick_q;
	logic [CW-1:0] best_q;
	logic found_q;
	logic [NW-1:0] n_q;

	logic [TW-1:0] out_task_q;
	logic [CW-1:0] out_bid_q;
	logic [7:0] out_win_q;
	logic out_valid_q, out_last_q;

	// Table RAM: own cost, winning bid, winner
	logic ram_we;
	logic [TW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [CW-1:0] r_cost, r_bid;
	logic [7:0] r_win;

	bcta_ram #(.Width(EW), .Depth(bcta_pkg::MaxTasks)) u_table (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);
	assign r_cost = ram_rdata[CW-1:0];
	assign r_bid = ram_rdata[2*CW-1:CW];
	assign r_win = ram_rdata[EW-1:2*CW];

	logic s_fire, m_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign cfg_ready = (state_q == bcta_pkg::ST_IDLE);

	logic [NW-1:0] eff_limit;
	always_comb begin
		if (limit_q == 4'd0) eff_limit = NW'(1);
		else if (32'(limit_q) > bcta_pkg::MaxBundle) eff_limit = NW'(bcta_pkg::MaxBundle);
		else eff_limit = NW'(limit_q);
	end

	logic [SW-1:0] n_slot;
	assign n_slot = n_q[SW-1:0];

	// Shared compare unit
	logic peer_lt, peer_eq, claimable, better;
	assign peer_lt = amt_q < r_bid;
	assign peer_eq = amt_q == r_bid;
	assign claimable = loaded_q[scan_q] && !inb_q[scan_q] &&
		((r_win == own_id_q) || (r_cost < r_bid));
	assign better = claimable && (r_cost < best_q);

	logic peer_upd, peer_tie;
	assign peer_upd = loaded_q[idx_q] && peer_lt;
	assign peer_tie = loaded_q[idx_q] && !peer_lt && peer_eq && win_q != 8'd0 &&
		(r_win == 8'd0 || win_q < r_win);

	logic scan_end;
	assign scan_end = (32'(scan_q) == bcta_pkg::MaxTasks - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bcta_pkg::ST_IDLE:
				if (s_fire) begin
					case (s_axis_tdata[2:0])
						bcta_pkg::OP_LOAD, bcta_pkg::OP_PEER, bcta_pkg::OP_READ:
							state_d = bcta_pkg::ST_RD;
						bcta_pkg::OP_REBUILD: state_d = bcta_pkg::ST_CUT_RD;
						default: state_d = bcta_pkg::ST_SINGLE;
					endcase
				end
			bcta_pkg::ST_RD: state_d = bcta_pkg::ST_UPD;
			bcta_pkg::ST_UPD: state_d = bcta_pkg::ST_SINGLE;
			bcta_pkg::ST_CUT_RD:
				state_d = (n_q < blen_q) ? bcta_pkg::ST_CUT_CHK : bcta_pkg::ST_SCAN_RD;
			bcta_pkg::ST_CUT_CHK:
				state_d = (r_win != own_id_q) ? bcta_pkg::ST_SCAN_RD : bcta_pkg::ST_CUT_RD;
			bcta_pkg::ST_SCAN_RD:
				state_d = (blen_q < eff_limit) ? bcta_pkg::ST_SCAN_CHK : bcta_pkg::ST_OUT_RD;
			bcta_pkg::ST_SCAN_CHK:
				if (scan_end) begin
					state_d = (found_q || better) ? bcta_pkg::ST_CLAIM : bcta_pkg::ST_OUT_RD;
				end else begin
					state_d = bcta_pkg::ST_SCAN_RD;
				end
			bcta_pkg::ST_CLAIM: state_d = bcta_pkg::ST_SCAN_RD;
			bcta_pkg::ST_OUT_RD:
				state_d = (blen_q == '0) ? bcta_pkg::ST_SINGLE : bcta_pkg::ST_OUT_WAIT;
			bcta_pkg::ST_OUT_WAIT: state_d = bcta_pkg::ST_OUT;
			bcta_pkg::ST_OUT:
				if (m_fire) begin
					state_d = out_last_q ? bcta_pkg::ST_IDLE : bcta_pkg::ST_OUT_WAIT;
				end
			bcta_pkg::ST_SINGLE:
				if (m_fire) state_d = bcta_pkg::ST_IDLE;
			default: state_d = bcta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q;
		ram_wdata = {r_win, r_bid, r_cost};
		case (state_q)
			bcta_pkg::ST_UPD:
				if (op_q == bcta_pkg::OP_LOAD) begin
					ram_we = 1'b1;
					ram_wdata = {8'd0, bcta_pkg::CostInf, amt_q};
				end else if (op_q == bcta_pkg::OP_PEER && snd_q != own_id_q &&
					(peer_upd || peer_tie)) begin
					ram_we = 1'b1;
					ram_wdata = {win_q, peer_upd ? amt_q : r_bid, r_cost};
				end
			bcta_pkg::ST_CUT_RD, bcta_pkg::ST_CUT_CHK: ram_addr = bl_q[n_slot];
			bcta_pkg::ST_SCAN_RD: ram_addr = scan_q;
			// fetch the current best so the claim sees its row
			bcta_pkg::ST_SCAN_CHK: ram_addr = better ? scan_q : pick_q;
			bcta_pkg::ST_CLAIM: begin
				ram_addr = pick_q;
				ram_we = (r_win != own_id_q);
				ram_wdata = {own_id_q, r_cost, r_cost};
			end
			bcta_pkg::ST_OUT_RD: ram_addr = bl_q[0];
			bcta_pkg::ST_OUT_WAIT: ram_addr = bl_q[n_slot];
			// on a transfer, fetch the next entry
			bcta_pkg::ST_OUT: ram_addr = m_fire ? bl_q[n_slot + SW'(1)] : bl_q[n_slot];
			default: ram_addr = idx_q;
		endcase
	end

	assign s_axis_tready = (state_q == bcta_pkg::ST_IDLE);
	assign m_axis_tvalid = (state_q == bcta_pkg::ST_OUT) || (state_q == bcta_pkg::ST_SINGLE);
	assign m_axis_tlast = out_last_q;
	assign m_axis_tdata = {4'd0, out_valid_q, changed_q, blen_q, out_win_q, out_bid_q,
		out_task_q};

	always_ff @(posedge clk) begin
		if (state_q == bcta_pkg::ST_IDLE && s_fire) begin
			op_q <= s_axis_tdata[2:0];
			idx_q <= s_axis_tdata[8:3];
			amt_q <= s_axis_tdata[40:9];
			win_q <= s_axis_tdata[48:41];
			snd_q <= s_axis_tdata[56:49];
			first_q <= s_axis_tdata[57];
		end
		if (state_q == bcta_pkg::ST_CLAIM) begin
			bl_q[blen_q[SW-1:0]] <= pick_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcta_pkg::ST_IDLE;
			own_id_q <= 8'd1;
			limit_q <= 4'd1;
			loaded_q <= '0;
			inb_q <= '0;
			blen_q <= '0;
			changed_q <= 1'b0;
			scan_q <= '0;
			pick_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			n_q <= '0;
			out_task_q <= '0;
			out_bid_q <= '0;
			out_win_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bcta_pkg::CFG_AGENT_ID) own_id_q <= cfg_data;
				else limit_q <= cfg_data[3:0];
			end
			case (state_q)
				bcta_pkg::ST_IDLE: begin
					n_q <= '0;
					if (s_fire && s_axis_tdata[2:0] == bcta_pkg::OP_CLEAR) begin
						loaded_q <= '0;
						inb_q <= '0;
						blen_q <= '0;
						changed_q <= 1'b0;
					end
					out_task_q <= '0;
					out_bid_q <= '0;
					out_win_q <= '0;
					out_valid_q <= 1'b0;
					out_last_q <= 1'b1;
				end
				bcta_pkg::ST_UPD: begin
					out_task_q <= idx_q;
					if (op_q == bcta_pkg::OP_LOAD) begin
						loaded_q[idx_q] <= 1'b1;
						out_bid_q <= bcta_pkg::CostInf;
						out_win_q <= 8'd0;
						out_valid_q <= 1'b1;
					end else begin
						out_valid_q <= loaded_q[idx_q];
						out_bid_q <= loaded_q[idx_q] ? r_bid : '0;
						out_win_q <= loaded_q[idx_q] ? r_win : 8'd0;
						if (op_q == bcta_pkg::OP_PEER && snd_q != own_id_q) begin
							if (peer_upd) begin
								out_bid_q <= amt_q;
								out_win_q <= win_q;
								changed_q <= 1'b1;
							end else if (peer_tie) begin
								out_win_q <= win_q;
								changed_q <= 1'b1;
							end else if (first_q) begin
								changed_q <= 1'b0;
							end
						end
					end
				end
				bcta_pkg::ST_CUT_RD: if (n_q >= blen_q) begin
					scan_q <= '0;
					found_q <= 1'b0;
					best_q <= bcta_pkg::CostInf;
				end
				bcta_pkg::ST_CUT_CHK: begin
					if (r_win != own_id_q) begin
						// drop this slot and all after it
						blen_q <= n_q;
						changed_q <= 1'b1;
						scan_q <= '0;
						found_q <= 1'b0;
						best_q <= bcta_pkg::CostInf;
						for (int m = 0; m < bcta_pkg::MaxBundle; m++) begin
							if (NW'(m) >= n_q && NW'(m) < blen_q) inb_q[bl_q[m]] <= 1'b0;
						end
					end else begin
						n_q <= n_q + NW'(1);
					end
				end
				bcta_pkg::ST_SCAN_CHK: begin
					if (better) begin
						best_q <= r_cost;
						pick_q <= scan_q;
						found_q <= 1'b1;
					end
					scan_q <= scan_q + TW'(1);
					n_q <= '0;
				end
				bcta_pkg::ST_CLAIM: begin
					blen_q <= blen_q + NW'(1);
					inb_q[pick_q] <= 1'b1;
					scan_q <= '0;
					found_q <= 1'b0;
					best_q <= bcta_pkg::CostInf;
				end
				bcta_pkg::ST_OUT_RD: n_q <= '0;
				bcta_pkg::ST_OUT_WAIT: begin
					out_task_q <= bl_q[n_slot];
					out_bid_q <= r_bid;
					out_win_q <= r_win;
					out_valid_q <= 1'b1;
					out_last_q <= (n_q + NW'(1) == blen_q);
				end
				bcta_pkg::ST_OUT: if (m_fire) n_q <= n_q + NW'(1);
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		32'(blen_q) <= bcta_pkg::MaxBundle) else $error("bundle overflow");
	a_inb: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(inb_q)) == 32'(blen_q) || state_q != bcta_pkg::ST_IDLE)
		else $error("in_bundle count mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while busy");
`endif
endmodule

>>> src/bcta_ram.sv
// Generic single-port RAM with registered read.
module bcta_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> test/bundle_consensus_task_allocator_tb.sv
// Testbench: directed table and random traffic for the bundle consensus task allocator.
module bundle_consensus_task_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0]  task_id;
		logic [31:0] bid;
		logic [7:0]  winner;
		logic [3:0]  count;
		logic        changed;
		logic        valid;
		logic        last;
	} alloc_res_t;

	typedef struct {
		logic [2:0]  op;
		logic [5:0]  idx;
		logic [31:0] amount;
		logic [7:0]  win;
		logic [7:0]  sender;
		logic        first;
		bit          has_exp;
		alloc_res_t  exp;
	} stim_row_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [7:0] cfg_data;

	bundle_consensus_task_allocator u_top (.*);

	// predictor state
	logic [7:0]  my_id;
	logic [3:0]  limit_reg;
	bit          loaded[bcta_pkg::MaxTasks];
	logic [31:0] cost_tab[bcta_pkg::MaxTasks];
	logic [31:0] bid_tab[bcta_pkg::MaxTasks];
	logic [7:0]  win_tab[bcta_pkg::MaxTasks];
	bit          bundled[bcta_pkg::MaxTasks];
	logic [5:0]  blist[bcta_pkg::MaxBundle];
	int          blen;
	bit          chg;

	alloc_res_t expected_q[$];
	alloc_res_t override_q[$];
	int errors = 0;
	int cycles = 0;
	int n_results = 0;
	int n_items = 0;
	int burst_left = 0;

	function automatic alloc_res_t mk(logic [5:0] t, logic [31:0] b, logic [7:0] w,
			bit v, bit l);
		alloc_res_t r;
		r.task_id = t; r.bid = b; r.winner = w; r.count = blen[3:0];
		r.changed = chg; r.valid = v; r.last = l;
		return r;
	endfunction

	task automatic predict_reset();
		my_id = 8'd1; limit_reg = 4'd1; blen = 0; chg = 0;
		for (int i = 0; i < bcta_pkg::MaxTasks; i++) begin
			loaded[i] = 0; bundled[i] = 0;
		end
	endtask

	task automatic predict_rebuild();
		int lim, pick;
		logic [31:0] best;
		bit found, ok;
		lim = (limit_reg < 1) ? 1 : (limit_reg > bcta_pkg::MaxBundle) ?
			bcta_pkg::MaxBundle : int'(limit_reg);
		for (int n = 0; n < blen; n++) begin
			if (win_tab[blist[n]] != my_id) begin
				for (int m = n; m < blen; m++) bundled[blist[m]] = 0;
				blen = n; chg = 1;
				break;
			end
		end
		while (blen < lim) begin
			best = bcta_pkg::CostInf; found = 0; pick = 0;
			for (int i = 0; i < bcta_pkg::MaxTasks; i++) begin
				if (!loaded[i] || bundled[i]) continue;
				ok = (win_tab[i] == my_id) || (cost_tab[i] < bid_tab[i]);
				if (ok && cost_tab[i] < best) begin
					best = cost_tab[i]; pick = i; found = 1;
				end
			end
			if (!found) break;
			blist[blen] = 6'(pick); blen++; bundled[pick] = 1;
			if (win_tab[pick] != my_id) begin
				bid_tab[pick] = best; win_tab[pick] = my_id;
			end
		end
	endtask

	task automatic predict_item(logic [2:0] op, logic [5:0] idx, logic [31:0] amt,
			logic [7:0] w, logic [7:0] snd, logic first);
		case (op)
			bcta_pkg::OP_CLEAR: begin
				for (int i = 0; i < bcta_pkg::MaxTasks; i++) begin
					loaded[i] = 0; bundled[i] = 0;
				end
				blen = 0; chg = 0;
				expected_q = {expected_q, mk('0, '0, '0, 1'b0, 1'b1)};
				return;
			end
			bcta_pkg::OP_LOAD: begin
				loaded[idx] = 1; cost_tab[idx] = amt; bid_tab[idx] = bcta_pkg::CostInf;
				win_tab[idx] = 8'd0;
			end
			bcta_pkg::OP_PEER: begin
				if (snd != my_id) begin
					if (first) chg = 0;
					if (loaded[idx]) begin
						if (amt < bid_tab[idx]) begin
							bid_tab[idx] = amt; win_tab[idx] = w; chg = 1;
						end else if (amt == bid_tab[idx] && w != 0 &&
								(win_tab[idx] == 0 || w < win_tab[idx])) begin
							win_tab[idx] = w; chg = 1;
						end
					end
				end
			end
			bcta_pkg::OP_REBUILD: begin
				predict_rebuild();
				if (blen == 0) expected_q = {expected_q, mk('0, '0, '0, 1'b0, 1'b1)};
				else for (int n = 0; n < blen; n++)
					expected_q = {expected_q, mk(blist[n], bid_tab[blist[n]],
						win_tab[blist[n]], 1'b1, n + 1 == blen)};
				return;
			end
			bcta_pkg::OP_READ: ;
			default: begin
				expected_q = {expected_q, mk('0, '0, '0, 1'b0, 1'b1)};
				return;
			end
		endcase
		if (loaded[idx])
			expected_q = {expected_q, mk(idx, bid_tab[idx], win_tab[idx], 1'b1, 1'b1)};
		else expected_q = {expected_q, mk(idx, '0, '0, 1'b0, 1'b1)};
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	always @(posedge clk) if (cycles > 400000) begin
		$display("Mismatches found");
		$finish;
	end

	// receiver stall pattern
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_axis_tready <= 1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 9) == 0);
				default: m_axis_tready <= (cycles % 3 != 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.task_id = m_axis_tdata[5:0];
			got.bid = m_axis_tdata[37:6];
			got.winner = m_axis_tdata[45:38];
			got.count = m_axis_tdata[49:46];
			got.changed = m_axis_tdata[50];
			got.valid = m_axis_tdata[51];
			got.last = m_axis_tlast;
			n_results++;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.task_id != want.task_id) begin
					$error("task_out exp %0d got %0d", want.task_id, got.task_id); errors++;
				end
				if (got.bid != want.bid) begin
					$error("bid_out exp %h got %h", want.bid, got.bid); errors++;
				end
				if (got.winner != want.winner) begin
					$error("winner_out exp %0d got %0d", want.winner, got.winner); errors++;
				end
				if (got.count != want.count) begin
					$error("bundle_count exp %0d got %0d", want.count, got.count); errors++;
				end
				if (got.changed != want.changed) begin
					$error("changed_flag exp %0d got %0d", want.changed, got.changed); errors++;
				end
				if (got.valid != want.valid) begin
					$error("entry_valid exp %0d got %0d", want.valid, got.valid); errors++;
				end
				if (got.last != want.last) begin
					$error("tlast exp %0d got %0d", want.last, got.last); errors++;
				end
			end
		end
	end

	// stops the sender first, so a register write never meets an input transfer
	task automatic write_cfg(bcta_pkg::cfg_idx_t idx, logic [7:0] val);
		s_axis_tvalid <= 0;
		burst_left = 0;
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == bcta_pkg::CFG_AGENT_ID) my_id = val; else limit_reg = val[3:0];
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one transfer; valid stays high across back-to-back items within a burst
	task automatic send(logic [2:0] op, logic [5:0] idx, logic [31:0] amt, logic [7:0] w,
			logic [7:0] snd, logic first, bit rnd_gaps);
		int gap;
		if (rnd_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'b0, first, snd, w, amt, idx, op};
		do @(posedge clk); while (!s_axis_tready);
		predict_item(op, idx, amt, w, snd, first);
		n_items++;
		if (burst_left > 0) burst_left--;
	endtask

	stim_row_t rows[$];

	function automatic stim_row_t row(logic [2:0] op, logic [5:0] idx, logic [31:0] amt,
			logic [7:0] w, logic [7:0] snd, logic first);
		stim_row_t r;
		r.op = op; r.idx = idx; r.amount = amt; r.win = w; r.sender = snd; r.first = first;
		r.has_exp = 0; r.exp = '0;
		return r;
	endfunction

	task automatic random_peer_msg(int n);
		for (int k = 0; k < n; k++) begin
			logic [7:0] snd;
			snd = ($urandom_range(0, 9) == 0) ? my_id : 8'($urandom_range(1, 255));
			send(bcta_pkg::OP_PEER, 6'($urandom_range(0, 15)),
				($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 300),
				($urandom_range(0, 4) == 0) ? my_id : 8'($urandom_range(0, 255)),
				snd, k == 0, 1);
		end
	endtask

	initial begin
		stim_row_t r;
		s_axis_tvalid = 0; s_axis_tdata = '0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		arst_n = 0;
		predict_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table; empty-state rows have known answers
		r = row(bcta_pkg::OP_READ, 6'd63, 32'd0, 8'd0, 8'd0, 1'b0); r.has_exp = 1;
		r.exp = '{task_id: 63, bid: 0, winner: 0, count: 0, changed: 0, valid: 0, last: 1};
		rows = {rows, r};
		r = row(bcta_pkg::OP_REBUILD, 6'd0, 32'd0, 8'd0, 8'd0, 1'b0); r.has_exp = 1;
		r.exp = '{task_id: 0, bid: 0, winner: 0, count: 0, changed: 0, valid: 0, last: 1};
		rows = {rows, r};
		r = row(3'd7, 6'd5, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1); r.has_exp = 1;
		r.exp = '{task_id: 0, bid: 0, winner: 0, count: 0, changed: 0, valid: 0, last: 1};
		rows = {rows, r};
		r = row(3'd5, 6'd0, 32'd0, 8'd0, 8'd0, 1'b0); r.has_exp = 1;
		r.exp = '{task_id: 0, bid: 0, winner: 0, count: 0, changed: 0, valid: 0, last: 1};
		rows = {rows, r};
		r = row(bcta_pkg::OP_LOAD, 6'd0, 32'd20, 8'd0, 8'd0, 1'b0); r.has_exp = 1;
		r.exp = '{task_id: 0, bid: 32'hFFFF_FFFF, winner: 0, count: 0, changed: 0,
			valid: 1, last: 1};
		rows = {rows, r};
		rows = {rows, row(bcta_pkg::OP_LOAD, 6'd63, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0)};
		rows = {rows, row(bcta_pkg::OP_LOAD, 6'd7, 32'd100, 8'd0, 8'd0, 1'b0)};
		rows = {rows, row(bcta_pkg::OP_LOAD, 6'd9, 32'd100, 8'd0, 8'd0, 1'b0)};
		// unloaded task
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd40, 32'd5, 8'd3, 8'd2, 1'b1)};
		// lower bid wins
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd7, 32'd50, 8'd9, 8'd200, 1'b1)};
		// tie, smaller id wins
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd7, 32'd50, 8'd4, 8'd200, 1'b0)};
		// tie, larger id loses
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd7, 32'd50, 8'd6, 8'd200, 1'b0)};
		// own id ignored
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd7, 32'd0, 8'd0, 8'd1, 1'b1)};
		// lower bid with no winner
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd9, 32'd100, 8'd0, 8'd3, 1'b0)};
		rows = {rows, row(bcta_pkg::OP_REBUILD, 6'd0, 32'd0, 8'd0, 8'd0, 1'b0)};
		rows = {rows, row(bcta_pkg::OP_READ, 6'd0, 32'd0, 8'd0, 8'd0, 1'b0)};
		// steal bundled task
		rows = {rows, row(bcta_pkg::OP_PEER, 6'd0, 32'd5, 8'hFF, 8'hFF, 1'b1)};
		// cut
		rows = {rows, row(bcta_pkg::OP_REBUILD, 6'd0, 32'd0, 8'd0, 8'd0, 1'b0)};
		rows = {rows, row(bcta_pkg::OP_LOAD, 6'd9, 32'hAAAA_5555, 8'd0, 8'd0, 1'b0)};
		rows = {rows, row(bcta_pkg::OP_READ, 6'd9, 32'd0, 8'd0, 8'd0, 1'b0)};
		foreach (rows[i]) begin
			if (rows[i].has_exp) override_q = {override_q, rows[i].exp};
			send(rows[i].op, rows[i].idx, rows[i].amount, rows[i].win, rows[i].sender,
				rows[i].first, 0);
			if (rows[i].has_exp) begin
				alloc_res_t a, b;
				a = override_q.pop_front(); b = expected_q[$];
				if (a != b) begin
					$error("table row %0d: typed %h predicted %h", i, a, b); errors++;
				end
			end
		end
		s_axis_tvalid <= 0;
		wait_idle();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_cfg(bcta_pkg::CFG_AGENT_ID, 8'd255);
					write_cfg(bcta_pkg::CFG_BUNDLE_LIMIT, 8'd8);
				end
				1: begin
					write_cfg(bcta_pkg::CFG_AGENT_ID, 8'd1);
					write_cfg(bcta_pkg::CFG_BUNDLE_LIMIT, 8'd0);
				end
				2: begin
					write_cfg(bcta_pkg::CFG_AGENT_ID, 8'hAA);
					write_cfg(bcta_pkg::CFG_BUNDLE_LIMIT, 8'd15);
				end
				3: begin
					write_cfg(bcta_pkg::CFG_AGENT_ID, 8'h55);
					write_cfg(bcta_pkg::CFG_BUNDLE_LIMIT, 8'd3);
				end
				default: begin
					write_cfg(bcta_pkg::CFG_AGENT_ID, 8'($urandom_range(1, 255)));
					write_cfg(bcta_pkg::CFG_BUNDLE_LIMIT, 8'($urandom_range(0, 15)));
				end
			endcase
			// load a small task set, then auction rounds
			for (int t = 0; t < 15; t++)
				send(bcta_pkg::OP_LOAD, 6'($urandom_range(0, 15)),
					($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 300),
					8'd0, 8'd0, 1'b0, 1);
			for (int rd = 0; rd < 3; rd++) begin
				send(bcta_pkg::OP_REBUILD, 6'd0, 32'd0, 8'd0, 8'd0, 1'b0, 1);
				random_peer_msg($urandom_range(1, 4));
				send(bcta_pkg::OP_READ, 6'($urandom_range(0, 63)), 32'd0, 8'd0, 8'd0,
					1'b0, 1);
			end
			// noise: full-range fields
			for (int k = 0; k < 3; k++)
				send(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom(),
					8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
					1'($urandom_range(0, 1)), 1);
			if (ph == 2) begin
				s_axis_tvalid <= 0;
				burst_left = 0;
				wait_idle();
			end
		end
		s_axis_tvalid <= 0;
		burst_left = 0;
		wait_idle();

		$display("Ran %0d items, %0d results, through six agent id and bundle limit settings",
			n_items, n_results);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

>>> filelist.f
src/bcta_pkg.sv
src/bcta_ram.sv
src/bundle_consensus_task_allocator.sv
test/bundle_consensus_task_allocator_tb.sv
